// ===== design/ths_pkg.sv =====
package ths_pkg;

    // angle resolution: a full turn is 2**ANGLE_BITS
    localparam int ANGLE_BITS = 16;

    // word field widths
    localparam int POS_W        = 31;
    localparam int OUT_W        = 16;
    localparam int MIN_STEP_W   = 20;
    localparam int ALPHA_W      = 17;
    localparam int ALPHA_SHIFT  = 16;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 32;

    // datapath widths
    localparam int DIFF_W       = POS_W + 1;
    localparam int MUL_W        = DIFF_W + 1;
    localparam int PROD_W       = 64;

    // cordic unit
    localparam int CW           = 48;
    localparam int NORM_TOP     = 40;
    localparam int COARSE_TOP   = 32;
    localparam int COARSE_SHIFT = NORM_TOP - COARSE_TOP;
    localparam int ROT_STEPS    = 32;
    localparam int STEP_W       = $clog2(ROT_STEPS);
    localparam int Z_W          = 32;
    localparam int Z_DROP       = Z_W - ANGLE_BITS;
    localparam int Z_RND        = (1 << Z_DROP) >> 1;

    // output rescale from ANGLE_BITS to a 16 bit angle
    localparam int OUT_SHR      = (ANGLE_BITS >= OUT_W) ? (ANGLE_BITS - OUT_W) : 0;
    localparam int OUT_SHL      = (ANGLE_BITS < OUT_W) ? (OUT_W - ANGLE_BITS) : 0;
    localparam int OUT_RND      = (1 << OUT_SHR) >> 1;
    localparam int OUT_TW       = ANGLE_BITS + OUT_W + 1;

    localparam logic [Z_W-1:0] Z_HALF = {1'b1, {(Z_W-1){1'b0}}};

    // register reset values
    localparam logic [MIN_STEP_W-1:0] MIN_STEP_RST = MIN_STEP_W'(600);
    localparam logic [ALPHA_W-1:0]    ALPHA_RST    = ALPHA_W'(39322);

    typedef logic [ANGLE_BITS-1:0] angle_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_STEP = CFG_IDX_W'(0),
        REG_ALPHA    = CFG_IDX_W'(1)
    } cfg_idx_t;

    typedef struct packed {
        logic [MIN_STEP_W-1:0] min_step_mm;
        logic [ALPHA_W-1:0]    smoothing_alpha;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_L,
        S_CMP,
        S_ATAN,
        S_DIFF,
        S_APPLY,
        S_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_NORM,
        C_ROT,
        C_DONE
    } cordic_state_t;

    // atan(2**-i) as a 32 bit binary angle
    localparam logic [Z_W-1:0] ARC_TABLE [ROT_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // rescale an internal angle to the 16 bit output angle
    function automatic logic [OUT_W-1:0] to_out16(input angle_t h);
        logic [OUT_TW-1:0] t;
        t = OUT_TW'(h);
        if (ANGLE_BITS >= OUT_W)
        begin
            t = (t + OUT_TW'(OUT_RND)) >> OUT_SHR;
        end
        else
        begin
            t = t << OUT_SHL;
        end
        return t[OUT_W-1:0];
    endfunction

endpackage

// ===== design/ths_pos_if.sv =====
interface ths_pos_if import ths_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink (input valid, input pos_x, input pos_y, output ready);
endinterface

// ===== design/ths_head_if.sv =====
interface ths_head_if import ths_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    heading_valid;
    logic signed [OUT_W-1:0] heading_angle;

    modport source (output valid, output heading_valid, output heading_angle, input ready);
    modport sink (input valid, input heading_valid, input heading_angle, output ready);
endinterface

// ===== design/ths_cfg_if.sv =====
interface ths_cfg_if import ths_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output idx, output data, input ready);
    modport sink (input valid, input idx, input data, output ready);
endinterface

// ===== design/ths_cfg_regs.sv =====
module ths_cfg_regs import ths_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    ths_cfg_if.sink   cfg,
    output cfg_t      regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    // always able to take a write
    assign cfg.ready = 1'b1;

    // register decode, unknown index leaves everything as is
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.idx)
                REG_MIN_STEP: regs_next.min_step_mm     = cfg.data[MIN_STEP_W-1:0];
                REG_ALPHA:    regs_next.smoothing_alpha = cfg.data[ALPHA_W-1:0];
                default:      regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.min_step_mm     <= MIN_STEP_RST;
            regs_reg.smoothing_alpha <= ALPHA_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

// ===== design/ths_cordic.sv =====
module ths_cordic import ths_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DIFF_W-1:0] dx,
    input  logic signed [DIFF_W-1:0] dy,
    output cordic_stat_t             stat,
    output angle_t                   raw
);

    cordic_state_t         state_reg;
    cordic_state_t         state_next;
    logic signed [CW-1:0]  x_reg;
    logic signed [CW-1:0]  x_next;
    logic signed [CW-1:0]  y_reg;
    logic signed [CW-1:0]  y_next;
    logic signed [CW-1:0]  m_reg;
    logic signed [CW-1:0]  m_next;
    logic [Z_W-1:0]        z_reg;
    logic [Z_W-1:0]        z_next;
    logic [Z_W-1:0]        z_round;
    logic [STEP_W-1:0]     i_reg;
    logic [STEP_W-1:0]     i_next;
    logic signed [CW-1:0]  x0;
    logic signed [CW-1:0]  y0;
    logic signed [CW-1:0]  y0_abs;
    logic signed [CW-1:0]  xs;
    logic signed [CW-1:0]  ys;
    logic                  flip;
    logic                  zero_vec;
    logic                  m_short;
    logic                  m_coarse;

    // seed vector, folded into the right half plane
    assign zero_vec = (dx == '0) && (dy == '0);
    assign flip     = dx[DIFF_W-1];
    assign x0       = flip ? -CW'(dx) : CW'(dx);
    assign y0       = flip ? -CW'(dy) : CW'(dy);
    assign y0_abs   = y0[CW-1] ? -y0 : y0;

    // normalize search: coarse step of several bits, then single bits
    assign m_short  = (m_reg[CW-1:NORM_TOP] == '0);
    assign m_coarse = (m_reg[CW-1:COARSE_TOP] == '0);

    // shared shifter for the rotation step
    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;

    // round the 32 bit angle to ANGLE_BITS
    assign z_round = z_reg + Z_W'(Z_RND);
    assign raw     = z_round[Z_W-1:Z_DROP];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    state_next = zero_vec ? C_DONE : C_NORM;
                end
            end
            C_NORM:
            begin
                if (!m_short)
                begin
                    state_next = C_ROT;
                end
            end
            C_ROT:
            begin
                if (i_reg == STEP_W'(ROT_STEPS - 1))
                begin
                    state_next = C_DONE;
                end
            end
            C_DONE:  state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    // status outputs
    always_comb
    begin
        stat.busy = (state_reg != C_IDLE);
        stat.done = (state_reg == C_DONE);
    end

    // vector and angle datapath
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        m_next = m_reg;
        z_next = z_reg;
        i_next = i_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    x_next = x0;
                    y_next = y0;
                    m_next = (x0 > y0_abs) ? x0 : y0_abs;
                    z_next = (flip && !zero_vec) ? Z_HALF : '0;
                    i_next = '0;
                end
            end
            C_NORM:
            begin
                if (m_short)
                begin
                    if (m_coarse)
                    begin
                        x_next = x_reg <<< COARSE_SHIFT;
                        y_next = y_reg <<< COARSE_SHIFT;
                        m_next = m_reg <<< COARSE_SHIFT;
                    end
                    else
                    begin
                        x_next = x_reg <<< 1;
                        y_next = y_reg <<< 1;
                        m_next = m_reg <<< 1;
                    end
                end
            end
            C_ROT:
            begin
                if (y_reg > 0)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + ARC_TABLE[i_reg];
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - ARC_TABLE[i_reg];
                end
                i_next = i_reg + STEP_W'(1);
            end
            default:
            begin
                x_next = x_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        m_reg <= m_next;
        z_reg <= z_next;
        i_reg <= i_next;
    end

endmodule

// ===== design/track_heading_smoother_core.sv =====
// sequence: the first word only sets the anchor; a later word runs 4 squaring/compare
// steps, and a taken move then runs the cordic normalize and 32 rotations (skipped for
// zero displacement), the smoothing multiply and update
// flow: one word at a time; a new word is taken only while the sequencer is idle
// reset: asynchronous active low; clears the anchor and heading present flags, loads register defaults
module track_heading_smoother_core import ths_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    ths_pos_if.sink     pos,
    ths_head_if.source  heading,
    ths_cfg_if.sink     cfg
);

    cfg_t                    cfg_q;
    seq_state_t              state_reg;
    seq_state_t              state_next;
    logic signed [POS_W-1:0] px_reg;
    logic signed [POS_W-1:0] py_reg;
    logic signed [POS_W-1:0] anchor_x_reg;
    logic signed [POS_W-1:0] anchor_y_reg;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic [DIFF_W-1:0]       ax;
    logic [DIFF_W-1:0]       ay;
    logic                    anchor_present_reg;
    logic                    heading_present_reg;
    angle_t                  heading_reg;
    angle_t                  raw;
    angle_t                  diff;
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic signed [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0]       acc_reg;
    logic                    take;
    logic                    out_valid_reg;
    logic                    out_hv_reg;
    logic signed [OUT_W-1:0] out_angle_reg;
    logic                    pos_ready;
    logic                    pos_acc;
    logic                    out_free;
    logic                    load_out;
    logic                    cordic_start;
    cordic_stat_t            cordic_stat;

    ths_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_q)
    );

    ths_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .dx    (dx_reg),
        .dy    (dy_reg),
        .stat  (cordic_stat),
        .raw   (raw)
    );

    // handshakes
    assign pos.ready     = pos_ready;
    assign pos_acc       = pos.valid && pos_ready;
    assign out_free      = !out_valid_reg || heading.ready;
    assign heading.valid = out_valid_reg;
    assign heading.heading_valid = out_hv_reg;
    assign heading.heading_angle = out_angle_reg;

    // displacement magnitudes and threshold test
    assign ax   = dx_reg[DIFF_W-1] ? -dx_reg : dx_reg;
    assign ay   = dy_reg[DIFF_W-1] ? -dy_reg : dy_reg;
    assign take = (acc_reg >= $unsigned(prod_reg));
    assign diff = raw - heading_reg;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ_X:
            begin
                mul_a = MUL_W'(ax);
                mul_b = MUL_W'(ax);
            end
            S_SQ_Y:
            begin
                mul_a = MUL_W'(ay);
                mul_b = MUL_W'(ay);
            end
            S_SQ_L:
            begin
                mul_a = MUL_W'(cfg_q.min_step_mm);
                mul_b = MUL_W'(cfg_q.min_step_mm);
            end
            S_DIFF:
            begin
                mul_a = MUL_W'(cfg_q.smoothing_alpha);
                mul_b = MUL_W'(signed'(diff));
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pos.valid)
                begin
                    state_next = anchor_present_reg ? S_SQ_X : S_DONE;
                end
            end
            S_SQ_X:  state_next = S_SQ_Y;
            S_SQ_Y:  state_next = S_SQ_L;
            S_SQ_L:  state_next = S_CMP;
            S_CMP:   state_next = take ? S_ATAN : S_DONE;
            S_ATAN:
            begin
                if (cordic_stat.done)
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:  state_next = heading_present_reg ? S_APPLY : S_DONE;
            S_APPLY: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        pos_ready    = (state_reg == S_IDLE);
        cordic_start = (state_reg == S_CMP) && take;
        load_out     = (state_reg == S_DONE) && out_free;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            anchor_present_reg  <= 1'b0;
            heading_present_reg <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pos_acc)
            begin
                anchor_present_reg <= 1'b1;
            end
            if (state_reg == S_DIFF)
            begin
                heading_present_reg <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (heading.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p[PROD_W-1:0];

        if (pos_acc)
        begin
            px_reg <= pos.pos_x;
            py_reg <= pos.pos_y;
            dx_reg <= DIFF_W'(pos.pos_x) - DIFF_W'(anchor_x_reg);
            dy_reg <= DIFF_W'(pos.pos_y) - DIFF_W'(anchor_y_reg);
        end

        // anchor: first word, or a move past the threshold
        if (pos_acc && !anchor_present_reg)
        begin
            anchor_x_reg <= pos.pos_x;
            anchor_y_reg <= pos.pos_y;
        end
        else if (cordic_start)
        begin
            anchor_x_reg <= px_reg;
            anchor_y_reg <= py_reg;
        end

        // squared distance accumulate
        if (state_reg == S_SQ_Y)
        begin
            acc_reg <= $unsigned(prod_reg);
        end
        else if (state_reg == S_SQ_L)
        begin
            acc_reg <= acc_reg + $unsigned(prod_reg);
        end

        // heading update
        if ((state_reg == S_DIFF) && !heading_present_reg)
        begin
            heading_reg <= raw;
        end
        else if (state_reg == S_APPLY)
        begin
            heading_reg <= heading_reg + prod_reg[ALPHA_SHIFT +: ANGLE_BITS];
        end

        // result word
        if (load_out)
        begin
            out_hv_reg    <= heading_present_reg;
            out_angle_reg <= heading_present_reg ? signed'(to_out16(heading_reg)) : '0;
        end
    end

`ifndef SYNTHESIS
    a_angle_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (heading.valid && !heading.heading_valid) |-> (heading.heading_angle == '0))
        else $error("heading angle not zero while heading is invalid");

    a_heading_needs_anchor: assert property (@(posedge clk) disable iff (!rst_n)
        heading_present_reg |-> anchor_present_reg)
        else $error("heading established without an anchor");

    a_heading_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        heading_present_reg |=> heading_present_reg)
        else $error("heading present flag dropped");

    a_cordic_busy_in_atan: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_stat.busy |-> (state_reg == S_ATAN))
        else $error("cordic running outside the atan step");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (pos.valid && pos.ready) |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after taking a word");
`endif

endmodule
